// File: sv/fdbb_pkg.sv
// Shared types, constants and helpers for the frame difference bounding box block.
package fdbb_pkg;

  // Largest frame dimension in pixels and the compared pixel width
  localparam int MAX_DIMENSION = 4096;
  localparam int PIXEL_BITS    = 8;

  // Field widths
  localparam int PIX_W     = 8;
  localparam int POS_BITS  = 12;
  localparam int SIZE_BITS = 13;
  localparam int CNT_BITS  = 25;

  // Only the low PIXEL_BITS bits of a pixel take part in the compare
  localparam int CMP_BITS = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // One input transaction: a pixel pair at the current raster position
  typedef struct packed {
    logic [PIX_W-1:0] source_pixel;
    logic [PIX_W-1:0] snapshot_pixel;
  } pixel_pair_t;

  // One result transaction per frame
  typedef struct packed {
    logic                 frames_equal;
    logic [CNT_BITS-1:0]  differing_count;
    logic [POS_BITS-1:0]  box_left;
    logic [POS_BITS-1:0]  box_top;
    logic [SIZE_BITS-1:0] box_right;
    logic [SIZE_BITS-1:0] box_bottom;
  } result_t;

  // Clamp a size register to 1..MAX_DIMENSION
  function automatic logic [SIZE_BITS-1:0] effective_size(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS-1:0] r;
    if (v == '0) begin
      r = SIZE_BITS'(1);
    end else if (v > SIZE_BITS'(MAX_DIMENSION)) begin
      r = SIZE_BITS'(MAX_DIMENSION);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/fdbb_tracker.sv
// Raster position counters, difference tally and bounding box tracking.
module fdbb_tracker
  import fdbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  pixel_pair_t          pair,
  input  logic [SIZE_BITS-1:0] frame_width,
  input  logic [SIZE_BITS-1:0] frame_height,
  output logic                 frame_end,
  output result_t              frame_result
);

  logic [POS_BITS-1:0] column_position;
  logic [POS_BITS-1:0] row_position;
  logic [CNT_BITS-1:0] difference_tally;
  logic [POS_BITS-1:0] lowest_column;
  logic [POS_BITS-1:0] lowest_row;
  logic [POS_BITS-1:0] highest_column;
  logic [POS_BITS-1:0] highest_row;

  logic [CNT_BITS-1:0] difference_tally_next;
  logic [POS_BITS-1:0] lowest_column_next;
  logic [POS_BITS-1:0] lowest_row_next;
  logic [POS_BITS-1:0] highest_column_next;
  logic [POS_BITS-1:0] highest_row_next;

  logic [SIZE_BITS-1:0] width_eff;
  logic [SIZE_BITS-1:0] height_eff;
  logic [SIZE_BITS-1:0] column_inc;
  logic [SIZE_BITS-1:0] row_inc;
  logic                 row_end;
  logic                 differ;

  // Compare the pair and find where the raster stands
  always_comb begin
    width_eff  = effective_size(frame_width);
    height_eff = effective_size(frame_height);
    column_inc = {1'b0, column_position} + SIZE_BITS'(1);
    row_inc    = {1'b0, row_position} + SIZE_BITS'(1);
    row_end    = column_inc >= width_eff;
    frame_end  = row_end && (row_inc >= height_eff);
    differ     = pair.source_pixel[CMP_BITS-1:0] != pair.snapshot_pixel[CMP_BITS-1:0];
  end

  // Fold the current pair into the tally and the box
  always_comb begin
    difference_tally_next = difference_tally;
    lowest_column_next    = lowest_column;
    lowest_row_next       = lowest_row;
    highest_column_next   = highest_column;
    highest_row_next      = highest_row;
    if (differ) begin
      difference_tally_next = difference_tally + CNT_BITS'(1);
      if (column_position < lowest_column) begin
        lowest_column_next = column_position;
      end
      if (row_position < lowest_row) begin
        lowest_row_next = row_position;
      end
      if (column_position > highest_column) begin
        highest_column_next = column_position;
      end
      if (row_position > highest_row) begin
        highest_row_next = row_position;
      end
    end
  end

  // Build the frame result from the updated values
  always_comb begin
    frame_result = '0;
    if (difference_tally_next == '0) begin
      frame_result.frames_equal = 1'b1;
    end else begin
      frame_result.differing_count = difference_tally_next;
      frame_result.box_left        = lowest_column_next;
      frame_result.box_top         = lowest_row_next;
      frame_result.box_right       = {1'b0, highest_column_next} + SIZE_BITS'(1);
      frame_result.box_bottom      = {1'b0, highest_row_next} + SIZE_BITS'(1);
    end
  end

  // Advance the raster and the tracking state; clear after the last pair
  always_ff @(posedge clk) begin
    if (rst || (take && frame_end)) begin
      column_position  <= '0;
      row_position     <= '0;
      difference_tally <= '0;
      lowest_column    <= '1;
      lowest_row       <= '1;
      highest_column   <= '0;
      highest_row      <= '0;
    end else if (take) begin
      difference_tally <= difference_tally_next;
      lowest_column    <= lowest_column_next;
      lowest_row       <= lowest_row_next;
      highest_column   <= highest_column_next;
      highest_row      <= highest_row_next;
      if (row_end) begin
        column_position <= '0;
        row_position    <= row_inc[POS_BITS-1:0];
      end else begin
        column_position <= column_inc[POS_BITS-1:0];
      end
    end
  end

endmodule

// File: sv/frame_diff_bounding_box.sv
// Top level of the frame difference bounding box block.
// Pixel pairs (source, snapshot) arrive in raster order, one transaction per clock at full
// rate unless pixel_stall holds them: each pair is registered, folded into the position
// counters, the difference tally and the running min/max of column and row, and the last
// pair of a frame loads one result transaction into the output register. The tracking
// registers update as each pair is taken, so the rate holds at one pair per clock;
// pixel_stall rises only when a frame result is ready while the previous one still waits
// at a stalled output. The user must write frame_width and frame_height only while no
// frame is in flight (unchecked by the block); 0 acts as 1, values above 4096 act as 4096.
module frame_diff_bounding_box
  import fdbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  pixel_pair_t          pixel,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data
);

  logic [SIZE_BITS-1:0] frame_width;
  logic [SIZE_BITS-1:0] frame_height;

  logic        s1_valid;
  pixel_pair_t s1_pair;
  logic        s1_take;
  logic        out_free;
  logic        frame_end;
  result_t     frame_result;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIZE_BITS'(1);
      frame_height <= SIZE_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the stage when a frame result cannot reach the output register
  assign out_free    = !result_valid || !result_stall;
  assign s1_take     = s1_valid && (!frame_end || out_free);
  assign pixel_stall = s1_valid && !s1_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_valid && !pixel_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      s1_pair <= pixel;
    end
  end

  fdbb_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .take         (s1_take),
    .pair         (s1_pair),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .frame_end    (frame_end),
    .frame_result (frame_result)
  );

  // Result register: load at frame end, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_take && frame_end) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && frame_end) begin
      result <= frame_result;
    end
  end

  // An exact match carries an empty box and no count
  a_exact_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frames_equal |->
      result.differing_count == '0 && result.box_right == '0 && result.box_bottom == '0)
    else $error("exact match with nonempty result");

  // A frame with differences carries a nonempty box
  a_box_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.frames_equal |->
      result.differing_count != '0 && result.box_right > {1'b0, result.box_left}
      && result.box_bottom > {1'b0, result.box_top})
    else $error("difference result with empty box");

  // A finished frame never overwrites a result that still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && frame_end && result_valid && result_stall |-> !s1_take && pixel_stall)
    else $error("frame result would overwrite a stalled result");

endmodule

// File: test/frame_diff_bounding_box_tb.sv
// Self-checking testbench for the frame difference bounding box block.
module frame_diff_bounding_box_tb;
  import fdbb_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PAIRS   = 850;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_PRINTED    = 20;

  // How the pixels of one frame are chosen
  typedef enum logic [0:0] {
    FILL_CHANCE = 1'b0,  // each pair differs with a given percent chance
    FILL_MARK   = 1'b1   // only the pair at the marked position differs
  } fill_t;

  // One frame of stimulus, optionally with a size change part way through
  typedef struct packed {
    bit                   set_size;
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
    fill_t                fill;
    int                   chance;
    logic [POS_BITS-1:0]  mark_col;
    logic [POS_BITS-1:0]  mark_row;
    int                   cut_after;
    logic [SIZE_BITS-1:0] new_width;
    logic [SIZE_BITS-1:0] new_height;
    bit                   typed;
    result_t              want;
  } frame_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  pixel_pair_t          pixel = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [0:0]           cfg_index = REG_FRAME_WIDTH;
  logic [SIZE_BITS-1:0] cfg_data = '0;

  // Tracked copy of the size registers and the frame accumulators
  logic [SIZE_BITS-1:0] width_reg;
  logic [SIZE_BITS-1:0] height_reg;
  int col_pos, row_pos, tally, low_col, low_row, high_col, high_row;

  result_t    frame_results[$];
  frame_row_t frame_table[$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int sender_idle   = 0;
  int receiver_idle = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int pairs_sent    = 0;

  frame_diff_bounding_box dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("frame_diff_bounding_box_tb failed");
      $finish;
    end
  end

  function automatic int clamp_size(input logic [SIZE_BITS-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    col_pos  = 0;
    row_pos  = 0;
    tally    = 0;
    low_col  = (1 << POS_BITS) - 1;
    low_row  = (1 << POS_BITS) - 1;
    high_col = 0;
    high_row = 0;
  endfunction

  // Fold one pixel pair into the accumulators; return 1 when it closes the frame
  function automatic bit fold_pixel_pair(input pixel_pair_t p, output result_t r);
    int w, h;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    r = '0;
    if (p.source_pixel[CMP_BITS-1:0] != p.snapshot_pixel[CMP_BITS-1:0]) begin
      tally = (tally + 1) & ((1 << CNT_BITS) - 1);
      if (col_pos < low_col) low_col = col_pos;
      if (row_pos < low_row) low_row = row_pos;
      if (col_pos > high_col) high_col = col_pos;
      if (row_pos > high_row) high_row = row_pos;
    end
    // Advance the raster position; a short row or short frame ends early
    if (col_pos + 1 < w) begin
      col_pos = col_pos + 1;
      return 1'b0;
    end
    col_pos = 0;
    if (row_pos + 1 < h) begin
      row_pos = row_pos + 1;
      return 1'b0;
    end
    if (tally == 0) begin
      r.frames_equal = 1'b1;
    end else begin
      r.differing_count = CNT_BITS'(tally);
      r.box_left        = POS_BITS'(low_col);
      r.box_top         = POS_BITS'(low_row);
      r.box_right       = SIZE_BITS'(high_col + 1);
      r.box_bottom      = SIZE_BITS'(high_row + 1);
    end
    restart_frame();
    return 1'b1;
  endfunction

  function automatic result_t frame_summary(input bit m, input int cnt, input int l,
                                            input int t, input int r, input int b);
    result_t s;
    s.frames_equal    = m;
    s.differing_count = CNT_BITS'(cnt);
    s.box_left        = POS_BITS'(l);
    s.box_top         = POS_BITS'(t);
    s.box_right       = SIZE_BITS'(r);
    s.box_bottom      = SIZE_BITS'(b);
    return s;
  endfunction

  function automatic frame_row_t frame_row(input bit set_size, input int w, input int h,
                                           input fill_t fill, input int chance,
                                           input int mc, input int mr, input int cut,
                                           input int nw, input int nh,
                                           input bit typed, input result_t want);
    frame_row_t fr;
    fr.set_size   = set_size;
    fr.width      = SIZE_BITS'(w);
    fr.height     = SIZE_BITS'(h);
    fr.fill       = fill;
    fr.chance     = chance;
    fr.mark_col   = POS_BITS'(mc);
    fr.mark_row   = POS_BITS'(mr);
    fr.cut_after  = cut;
    fr.new_width  = SIZE_BITS'(nw);
    fr.new_height = SIZE_BITS'(nh);
    fr.typed      = typed;
    fr.want       = want;
    return fr;
  endfunction

  function automatic pixel_pair_t random_pair(input bit differ);
    pixel_pair_t p;
    p.source_pixel   = PIX_W'($urandom_range(255));
    p.snapshot_pixel = differ ? p.source_pixel ^ PIX_W'($urandom_range(1, 255))
                              : p.source_pixel;
    return p;
  endfunction

  // Mostly small sizes, with zero and one mixed in
  function automatic logic [SIZE_BITS-1:0] pick_size(input int top);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 15) return SIZE_BITS'(1);
    return SIZE_BITS'($urandom_range(2, top));
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Offer one pair, entered at a falling edge; return at the accepting rising edge
  task automatic send_pair(input pixel_pair_t p, output bit done, output result_t r);
    while ($urandom_range(99) < sender_idle) begin
      pixel_valid = 1'b0;
      pixel = pixel_pair_t'(16'($urandom));
      @(negedge clk);
    end
    pixel_valid = 1'b1;
    pixel = p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    done = fold_pixel_pair(p, r);
  endtask

  // Drain the block so that a register write finds it idle
  task automatic settle();
    pixel_valid = 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [SIZE_BITS-1:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = v;
    else height_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stream one whole frame, resizing part way through where the row asks
  task automatic run_frame(input frame_row_t fr);
    pixel_pair_t p;
    result_t     r;
    bit          done;
    int          sent;
    if (fr.set_size) begin
      settle();
      write_reg(REG_FRAME_WIDTH, fr.width);
      write_reg(REG_FRAME_HEIGHT, fr.height);
    end
    done = 1'b0;
    sent = 0;
    while (!done) begin
      if (fr.cut_after != 0 && sent == fr.cut_after) begin
        settle();
        write_reg(REG_FRAME_WIDTH, fr.new_width);
        write_reg(REG_FRAME_HEIGHT, fr.new_height);
      end
      if (fr.fill == FILL_MARK) begin
        if (col_pos == fr.mark_col && row_pos == fr.mark_row) begin
          p = {8'hFF, 8'h00};
        end else begin
          p = random_pair(1'b0);
        end
      end else begin
        p = random_pair($urandom_range(99) < fr.chance);
      end
      send_pair(p, done, r);
      if (done) frame_results.push_back(fr.typed ? fr.want : r);
      sent++;
      pairs_sent++;
      @(negedge clk);
    end
  endtask

  // Receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_idle);
    end
  end

  // Compare each result transaction with the oldest pending frame summary
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (frame_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no frame pending", result));
      end else begin
        want = frame_results.pop_front();
        check_field("frames_equal", 32'(result.frames_equal), 32'(want.frames_equal));
        check_field("differing_count", 32'(result.differing_count),
                    32'(want.differing_count));
        check_field("box_left", 32'(result.box_left), 32'(want.box_left));
        check_field("box_top", 32'(result.box_top), 32'(want.box_top));
        check_field("box_right", 32'(result.box_right), 32'(want.box_right));
        check_field("box_bottom", 32'(result.box_bottom), 32'(want.box_bottom));
      end
    end
  end

  initial begin
    frame_row_t fr;
    bit         pressure_done;
    pressure_done = 1'b0;
    width_reg  = SIZE_BITS'(1);
    height_reg = SIZE_BITS'(1);
    restart_frame();

    // Hold reset, release on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    sender_idle   = 10;
    receiver_idle = 76;

    // Directed frames: reset size, extremes, clamping and mid-frame resizing
    frame_table.push_back(frame_row(0, 1, 1, FILL_CHANCE, 0, 0, 0, 0, 0, 0,
                                    1, frame_summary(1, 0, 0, 0, 0, 0)));
    frame_table.push_back(frame_row(0, 1, 1, FILL_MARK, 0, 0, 0, 0, 0, 0,
                                    1, frame_summary(0, 1, 0, 0, 1, 1)));
    frame_table.push_back(frame_row(1, 4, 3, FILL_CHANCE, 100, 0, 0, 0, 0, 0,
                                    1, frame_summary(0, 12, 0, 0, 4, 3)));
    frame_table.push_back(frame_row(1, 0, 0, FILL_MARK, 0, 0, 0, 0, 0, 0,
                                    1, frame_summary(0, 1, 0, 0, 1, 1)));
    frame_table.push_back(frame_row(1, 7, 5, FILL_CHANCE, 50, 0, 0, 0, 0, 0, 0, '0));
    frame_table.push_back(frame_row(1, 5, 5, FILL_MARK, 0, 2, 3, 0, 0, 0,
                                    1, frame_summary(0, 1, 2, 3, 3, 4)));
    frame_table.push_back(frame_row(1, 8, 4, FILL_CHANCE, 100, 0, 0, 13, 3, 4, 0, '0));
    frame_table.push_back(frame_row(1, 4, 6, FILL_CHANCE, 50, 0, 0, 17, 4, 2, 0, '0));
    frame_table.push_back(frame_row(1, 2, 2, FILL_CHANCE, 100, 0, 0, 3, 1, 1, 0, '0));
    frame_table.push_back(frame_row(1, 3, 1, FILL_CHANCE, 0, 0, 0, 1, 0, 0, 0, '0));
    frame_table.push_back(frame_row(1, 3, 2, FILL_CHANCE, 100, 0, 0, 2, 6, 2, 0, '0));
    frame_table.push_back(frame_row(1, 16, 16, FILL_CHANCE, 5, 0, 0, 0, 0, 0, 0, '0));
    foreach (frame_table[i]) run_frame(frame_table[i]);

    // Random frames in three idling phases
    pairs_sent = 0;
    while (pairs_sent < RANDOM_PAIRS) begin
      if (pairs_sent >= 2 * RANDOM_PAIRS / 3) begin
        sender_idle   = 0;
        receiver_idle = 0;
        if (!pressure_done) begin
          // Back up the output with one-pixel frames during a long hold-off
          fr = frame_row(1, 1, 1, FILL_CHANCE, 50, 0, 0, 0, 0, 0, 0, '0);
          run_frame(fr);
          hold_requests++;
          fr.set_size = 1'b0;
          repeat (40) run_frame(fr);
          pressure_done = 1'b1;
        end
      end else if (pairs_sent >= RANDOM_PAIRS / 3) begin
        sender_idle   = 76;
        receiver_idle = 10;
      end
      fr = '0;
      fr.set_size = ($urandom_range(99) < 40);
      fr.width    = pick_size(($urandom_range(9) == 0) ? 48 : 12);
      fr.height   = pick_size(6);
      fr.fill     = FILL_CHANCE;
      case ($urandom_range(3))
        0:       fr.chance = 0;
        1:       fr.chance = 5;
        2:       fr.chance = 50;
        default: fr.chance = 100;
      endcase
      if ($urandom_range(99) < 10) begin
        fr.cut_after  = $urandom_range(1, 8);
        fr.new_width  = pick_size(12);
        fr.new_height = pick_size(6);
      end
      run_frame(fr);
    end

    // Wait out the last results, then judge
    settle();
    if (fail_count == 0) begin
      $display("frame_diff_bounding_box_tb passed");
    end else begin
      $display("frame_diff_bounding_box_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/fdbb_pkg.sv
sv/fdbb_tracker.sv
sv/frame_diff_bounding_box.sv
test/frame_diff_bounding_box_tb.sv
